FILE: src/mtd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mtd_pkg
// Shared types and constants of the multi-tap detector: field widths,
// register indexes, register reset values and the beat layouts.
// ============================================================================
package mtd_pkg;

    // Field widths
    localparam int PosW   = 16;
    localparam int TimeW  = 32;
    localparam int CountW = 4;
    localparam int MsW    = 16;
    localparam int DistW  = 12;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_REQUIRED_TAPS      = 3'd0,
        REG_MAX_PRESS_MS       = 3'd1,
        REG_MAX_PRESS_DIST     = 3'd2,
        REG_MAX_GAP_MS         = 3'd3,
        REG_MAX_GAP_DIST       = 3'd4,
        REG_CANCEL_PROPAGATION = 3'd5
    } cfg_reg_t;

    // Register reset values
    localparam logic [CountW-1:0] RST_REQUIRED_TAPS  = 4'd1;
    localparam logic [MsW-1:0]    RST_MAX_PRESS_MS   = 16'd150;
    localparam logic [DistW-1:0]  RST_MAX_PRESS_DIST = 12'd15;
    localparam logic [MsW-1:0]    RST_MAX_GAP_MS     = 16'd220;
    localparam logic [DistW-1:0]  RST_MAX_GAP_DIST   = 12'd15;

    // Event kinds
    localparam logic KIND_DOWN = 1'b0;
    localparam logic KIND_UP   = 1'b1;

    // One touch event
    typedef struct packed {
        logic                   kind;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic [TimeW-1:0]       time_ms;
        logic                   in_bounds;
    } event_t;

    // One detector result
    typedef struct packed {
        logic                   accepted;
        logic                   recognized;
        logic signed [PosW-1:0] tap_x;
        logic signed [PosW-1:0] tap_y;
        logic                   stop_propagation;
        logic [CountW-1:0]      tap_count;
    } result_t;

endpackage

FILE: src/mtd_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// mtd_in_if
// Valid/ready channel carrying one touch event per beat.
// ============================================================================
interface mtd_in_if
    import mtd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic [TimeW-1:0]       time_ms;
    logic                   in_bounds;

    modport source (output valid, kind, pos_x, pos_y, time_ms, in_bounds, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, time_ms, in_bounds, output ready);
endinterface

FILE: src/mtd_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// mtd_out_if
// Valid/ready channel carrying one detector result per beat.
// ============================================================================
interface mtd_out_if
    import mtd_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   accepted;
    logic                   recognized;
    logic signed [PosW-1:0] tap_x;
    logic signed [PosW-1:0] tap_y;
    logic                   stop_propagation;
    logic [CountW-1:0]      tap_count;

    modport source (output valid, accepted, recognized, tap_x, tap_y, stop_propagation,
                    tap_count, input ready);
    modport sink   (input valid, accepted, recognized, tap_x, tap_y, stop_propagation,
                    tap_count, output ready);
endinterface

FILE: src/multi_tap_detector_core.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_tap_detector_core
// Multi-tap gesture detector over touch-down and touch-up events.
//
// Usage: touch events arrive as beats on in_ch (valid/ready); every event
// yields exactly one result beat on out_ch, in order. The result carries
// whether a down was accepted, whether the gesture completed, the last down
// position on completion, the stop-propagation request and the tap count.
// Thresholds are written through cfg_we/cfg_index/cfg_data while idle.
// An accepted event is held in the input register and is evaluated into
// the result register once that register is free to take it.
// Throughput: one event per cycle while out_ch does not stall; the event is
// evaluated by one pass of logic (a single distance check) between the input and result registers.
// Reset clears the tap state and restores the threshold defaults (one tap,
// 150 ms press, 15 px travel, 220 ms gap, 15 px gap, no cancel).
// When out_ch stalls the result register holds and the input register
// still takes one more event; after that in_ch.ready drops until the
// result beat is taken.
// ============================================================================
module multi_tap_detector_core
    import mtd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    mtd_in_if.sink              in_ch,
    mtd_out_if.source           out_ch,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);
    // Configuration
    logic [CountW-1:0] required_taps_reg;
    logic [MsW-1:0]    max_press_ms_reg;
    logic [DistW-1:0]  max_press_dist_reg;
    logic [MsW-1:0]    max_gap_ms_reg;
    logic [DistW-1:0]  max_gap_dist_reg;
    logic              cancel_prop_reg;

    // Detector state
    logic [CountW-1:0]      tap_counter_reg, tap_counter_next;
    logic                   recognizing_reg, recognizing_next;
    logic [TimeW-1:0]       down_time_reg, down_time_next;
    logic [TimeW-1:0]       up_time_reg, up_time_next;
    logic signed [PosW-1:0] down_x_reg, down_x_next;
    logic signed [PosW-1:0] down_y_reg, down_y_next;
    logic signed [PosW-1:0] up_x_reg, up_x_next;
    logic signed [PosW-1:0] up_y_reg, up_y_next;

    // Input and result registers
    logic    in_valid_reg;
    event_t  in_reg;
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic advance;
    logic in_take;

    // Shared distance unit
    logic signed [PosW-1:0] ref_x;
    logic signed [PosW-1:0] ref_y;
    logic [DistW-1:0]       dist_limit;
    logic                   dist_ok;

    logic [TimeW-1:0] gap_ms;
    logic [TimeW-1:0] press_ms;
    logic [CountW-1:0] count_inc;

    // Handshake
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_take     = in_ch.valid && in_ch.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            required_taps_reg  <= RST_REQUIRED_TAPS;
            max_press_ms_reg   <= RST_MAX_PRESS_MS;
            max_press_dist_reg <= RST_MAX_PRESS_DIST;
            max_gap_ms_reg     <= RST_MAX_GAP_MS;
            max_gap_dist_reg   <= RST_MAX_GAP_DIST;
            cancel_prop_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REQUIRED_TAPS:      required_taps_reg  <= cfg_data[CountW-1:0];
                REG_MAX_PRESS_MS:       max_press_ms_reg   <= cfg_data[MsW-1:0];
                REG_MAX_PRESS_DIST:     max_press_dist_reg <= cfg_data[DistW-1:0];
                REG_MAX_GAP_MS:         max_gap_ms_reg     <= cfg_data[MsW-1:0];
                REG_MAX_GAP_DIST:       max_gap_dist_reg   <= cfg_data[DistW-1:0];
                REG_CANCEL_PROPAGATION: cancel_prop_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pick the stored point and limit: a down is checked against the last
    // up for the gap, an up against the last down for the press travel
    always_comb
    begin
        if (in_reg.kind == KIND_DOWN)
        begin
            ref_x      = up_x_reg;
            ref_y      = up_y_reg;
            dist_limit = max_gap_dist_reg;
        end
        else
        begin
            ref_x      = down_x_reg;
            ref_y      = down_y_reg;
            dist_limit = max_press_dist_reg;
        end
    end

    mtd_dist_chk u_dist_chk (
        .a_x      (ref_x),
        .a_y      (ref_y),
        .b_x      (in_reg.pos_x),
        .b_y      (in_reg.pos_y),
        .limit    (dist_limit),
        .in_range (dist_ok)
    );

    assign gap_ms    = in_reg.time_ms - up_time_reg;
    assign press_ms  = in_reg.time_ms - down_time_reg;
    assign count_inc = tap_counter_reg + CountW'(1);

    // Evaluate one event
    always_comb
    begin
        tap_counter_next = tap_counter_reg;
        recognizing_next = recognizing_reg;
        down_time_next   = down_time_reg;
        up_time_next     = up_time_reg;
        down_x_next      = down_x_reg;
        down_y_next      = down_y_reg;
        up_x_next        = up_x_reg;
        up_y_next        = up_y_reg;

        out_next.accepted         = 1'b1;
        out_next.recognized       = 1'b0;
        out_next.tap_x            = '0;
        out_next.tap_y            = '0;
        out_next.stop_propagation = 1'b0;

        if (in_reg.kind == KIND_DOWN)
        begin
            if (recognizing_reg && (tap_counter_reg == '0))
            begin
                // Stale recognition with no taps: drop to idle, refuse
                tap_counter_next  = '0;
                recognizing_next  = 1'b0;
                out_next.accepted = 1'b0;
            end
            else
            begin
                down_x_next = in_reg.pos_x;
                down_y_next = in_reg.pos_y;
                if (!in_reg.in_bounds)
                begin
                    out_next.accepted = 1'b0;
                end
                else
                begin
                    down_time_next = in_reg.time_ms;
                    // Restart the count on a gap too long or too far
                    if ((tap_counter_reg != '0) && (tap_counter_reg < required_taps_reg)
                        && ((gap_ms > {{(TimeW-MsW){1'b0}}, max_gap_ms_reg}) || !dist_ok))
                    begin
                        tap_counter_next = '0;
                    end
                    recognizing_next = 1'b1;
                end
            end
        end
        else
        begin
            up_time_next = in_reg.time_ms;
            up_x_next    = in_reg.pos_x;
            up_y_next    = in_reg.pos_y;
            if ((press_ms <= {{(TimeW-MsW){1'b0}}, max_press_ms_reg}) && dist_ok)
            begin
                tap_counter_next = count_inc;
                if (count_inc == required_taps_reg)
                begin
                    out_next.recognized       = 1'b1;
                    out_next.tap_x            = down_x_reg;
                    out_next.tap_y            = down_y_reg;
                    out_next.stop_propagation = cancel_prop_reg;
                    tap_counter_next          = '0;
                    recognizing_next          = 1'b0;
                end
            end
            else
            begin
                tap_counter_next = '0;
                recognizing_next = 1'b0;
            end
        end

        out_next.tap_count = tap_counter_next;
    end

    // Control registers and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            tap_counter_reg <= '0;
            recognizing_reg <= 1'b0;
            down_time_reg   <= '0;
            up_time_reg     <= '0;
            down_x_reg      <= '0;
            down_y_reg      <= '0;
            up_x_reg        <= '0;
            up_y_reg        <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                tap_counter_reg <= tap_counter_next;
                recognizing_reg <= recognizing_next;
                down_time_reg   <= down_time_next;
                up_time_reg     <= up_time_next;
                down_x_reg      <= down_x_next;
                down_y_reg      <= down_y_next;
                up_x_reg        <= up_x_next;
                up_y_reg        <= up_y_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.kind      <= in_ch.kind;
            in_reg.pos_x     <= in_ch.pos_x;
            in_reg.pos_y     <= in_ch.pos_y;
            in_reg.time_ms   <= in_ch.time_ms;
            in_reg.in_bounds <= in_ch.in_bounds;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    // Drive the result channel
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.accepted         = out_reg.accepted;
    assign out_ch.recognized       = out_reg.recognized;
    assign out_ch.tap_x            = out_reg.tap_x;
    assign out_ch.tap_y            = out_reg.tap_y;
    assign out_ch.stop_propagation = out_reg.stop_propagation;
    assign out_ch.tap_count        = out_reg.tap_count;
endmodule

FILE: src/mtd_dist_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// mtd_dist_chk
// Euclidean distance limit check: squared distance between two points
// against the squared limit, exact, in one pass of combinational logic.
// ============================================================================
module mtd_dist_chk
    import mtd_pkg::*;
(
    input  logic signed [PosW-1:0] a_x,
    input  logic signed [PosW-1:0] a_y,
    input  logic signed [PosW-1:0] b_x,
    input  logic signed [PosW-1:0] b_y,
    input  logic [DistW-1:0]       limit,
    output logic                   in_range
);
    logic signed [PosW:0]       dx;
    logic signed [PosW:0]       dy;
    logic signed [2*PosW+1:0]   sq_x_full;
    logic signed [2*PosW+1:0]   sq_y_full;
    logic [2*PosW-1:0]          sq_x;
    logic [2*PosW-1:0]          sq_y;
    logic [2*PosW:0]            d2;
    logic [2*DistW-1:0]         lim2;

    // Differences need one extra bit
    assign dx = PosW'(0) + ({a_x[PosW-1], a_x} - {b_x[PosW-1], b_x});
    assign dy = PosW'(0) + ({a_y[PosW-1], a_y} - {b_y[PosW-1], b_y});

    // Square each axis; a square of a 16-bit magnitude fits 32 bits
    assign sq_x_full = dx * dx;
    assign sq_y_full = dy * dy;
    assign sq_x = sq_x_full[2*PosW-1:0];
    assign sq_y = sq_y_full[2*PosW-1:0];

    // Sum and compare against the squared limit
    assign d2       = {1'b0, sq_x} + {1'b0, sq_y};
    assign lim2     = limit * limit;
    assign in_range = (d2 <= {{(2*PosW+1-2*DistW){1'b0}}, lim2});
endmodule
